[hw/rtl/wsd_pkg.sv]
package wsd_pkg;

    localparam int COUNT_BITS = 20;
    localparam int CFG_W      = 20;
    localparam int ACC_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int ADDR_W     = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [CFG_W-1:0]  MAX_PAYLOAD_RST  = CFG_W'(10256);
    localparam logic [ADDR_W-1:0] REG_MAX_PAYLOAD  = ADDR_W'(0);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FRAGMENT  = 3'd1;
    localparam logic [2:0] ST_BAD_OP    = 3'd2;
    localparam logic [2:0] ST_CLOSE     = 3'd3;
    localparam logic [2:0] ST_OVERSIZE  = 3'd4;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic       is_open;
        logic [7:0] data;
    } wsd_item_t;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data_byte;
        logic [3:0] frame_opcode;
        logic       frame_last;
        logic [2:0] status;
    } wsd_result_t;

    function automatic logic [2:0] end_status(input logic fin, input logic [3:0] opc);
        logic [2:0] st;
        begin
            if (!fin)
            begin
                st = ST_FRAGMENT;
            end
            else
            begin
                case (opc)
                    OP_CLOSE:                               st = ST_CLOSE;
                    OP_TEXT, OP_BINARY, OP_PING, OP_PONG:   st = ST_OK;
                    default:                                st = ST_BAD_OP;
                endcase
            end
            return st;
        end
    endfunction

endpackage

[hw/rtl/wsd_front.sv]
module wsd_front
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // byte_value
    input  logic       s_axis_tuser,   // command
    output logic       item_valid,
    output wsd_item_t  item,
    input  logic       item_pop
);

    wsd_item_t             queue_mem [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]       count_reg, count_next;
    logic                  push;
    logic                  pop;
    wsd_item_t             in_item;

    assign s_axis_tready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign item_valid    = (count_reg != '0);
    assign pop           = item_pop && item_valid;
    assign item          = queue_mem[rd_ptr_reg];

    always_comb
    begin
        in_item.is_open = s_axis_tuser;
        in_item.data    = s_axis_tdata;
        wr_ptr_next     = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next     = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next      = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hw/rtl/wsd_parser.sv]
module wsd_parser
    import wsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] max_payload,
    input  logic             item_valid,
    input  wsd_item_t        item,
    output logic             item_pop,
    output logic             res_valid,
    output wsd_result_t      res,
    input  logic             res_ready
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_LEN16,
        PH_LEN64,
        PH_MASK,
        PH_PAYLOAD
    } phase_t;

    localparam logic [ACC_W-1:0] CNT_MAX = ACC_W'({COUNT_BITS{1'b1}});

    phase_t                phase_reg, phase_next;
    logic                  active_reg, active_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic [7:0]            first_reg, first_next;
    logic                  final_reg, final_next;
    logic [3:0]            opc_reg, opc_next;
    logic                  masked_reg, masked_next;
    logic [31:0]           key_reg, key_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;
    logic [COUNT_BITS-1:0] brx_reg, brx_next;
    logic                  out_valid_reg, out_valid_next;
    wsd_result_t           out_reg, out_next;

    logic                  slot_free;
    logic                  advance;
    logic                  emit;
    logic                  do_len;
    logic                  do_end;
    logic                  has;
    logic [7:0]            dbyte;
    logic [7:0]            key_byte;
    logic [2:0]            st;
    logic [ACC_W-1:0]      lim;
    logic [7:0]            b;

    assign slot_free = !out_valid_reg || res_ready;
    assign advance   = item_valid && slot_free;
    assign item_pop  = advance;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign b         = item.data;
    assign lim       = (ACC_W'(max_payload) > CNT_MAX) ? CNT_MAX : ACC_W'(max_payload);

    always_comb
    begin
        case (brx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        active_next = active_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        final_next  = final_reg;
        opc_next    = opc_reg;
        masked_next = masked_reg;
        key_next    = key_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        brx_next    = brx_reg;
        emit        = 1'b0;
        do_len      = 1'b0;
        do_end      = 1'b0;
        has         = 1'b0;
        dbyte       = 8'd0;
        st          = ST_OK;

        if (advance && item.is_open)
        begin
            active_next = 1'b1;
            phase_next  = PH_HDR;
            cnt_next    = 4'd0;
            brx_next    = '0;
        end
        else if (advance && active_reg)
        begin
            case (phase_reg)
                PH_LEN16:
                begin
                    acc_next = ACC_W'({acc_reg[7:0], b});
                    cnt_next = cnt_reg + 4'd1;
                    do_len   = (cnt_next >= 4'd2);
                end
                PH_LEN64:
                begin
                    ovf_next = ovf_reg || (acc_reg[ACC_W-1 -: 8] != 8'd0);
                    acc_next = {acc_reg[ACC_W-9:0], b};
                    cnt_next = cnt_reg + 4'd1;
                    do_len   = (cnt_next >= 4'd8);
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], b};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_next >= 4'd4)
                    begin
                        cnt_next = 4'd0;
                        if (acc_reg != '0)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            do_end = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    has      = 1'b1;
                    dbyte    = masked_reg ? (b ^ key_byte) : b;
                    brx_next = brx_reg + 1'b1;
                    emit     = 1'b1;
                    do_end   = (ACC_W'(brx_next) >= acc_reg);
                end
                default:
                begin
                    if (phase_reg != PH_HDR || cnt_reg == 4'd0)
                    begin
                        phase_next = PH_HDR;
                        first_next = b;
                        cnt_next   = 4'd1;
                    end
                    else
                    begin
                        final_next  = first_reg[7];
                        opc_next    = first_reg[3:0];
                        masked_next = b[7];
                        acc_next    = ACC_W'(b[6:0]);
                        ovf_next    = 1'b0;
                        brx_next    = '0;
                        cnt_next    = 4'd0;
                        key_next    = 32'd0;
                        if (b[6:0] == LEN_EXT16)
                        begin
                            acc_next   = '0;
                            phase_next = PH_LEN16;
                        end
                        else if (b[6:0] == LEN_EXT64)
                        begin
                            acc_next   = '0;
                            phase_next = PH_LEN64;
                        end
                        else
                        begin
                            do_len = 1'b1;
                        end
                    end
                end
            endcase

            if (do_len)
            begin
                cnt_next = 4'd0;
                brx_next = '0;
                if (ovf_next || (acc_next > lim))
                begin
                    active_next = 1'b0;
                    phase_next  = PH_HDR;
                    emit        = 1'b1;
                    st          = ST_OVERSIZE;
                end
                else if (masked_next)
                begin
                    phase_next = PH_MASK;
                end
                else if (acc_next != '0)
                begin
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    do_end = 1'b1;
                end
            end

            if (do_end)
            begin
                st = end_status(final_next, opc_next);
                if (st != ST_OK)
                begin
                    active_next = 1'b0;
                end
                phase_next = PH_HDR;
                cnt_next   = 4'd0;
                emit       = 1'b1;
            end
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (slot_free)
        begin
            out_valid_next = advance && emit;
        end
        if (advance && emit)
        begin
            out_next.has_data     = has;
            out_next.data_byte    = dbyte;
            out_next.frame_opcode = opc_next;
            out_next.frame_last   = do_end || (st == ST_OVERSIZE);
            out_next.status       = st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            active_reg    <= 1'b0;
            cnt_reg       <= 4'd0;
            first_reg     <= 8'd0;
            final_reg     <= 1'b0;
            opc_reg       <= 4'd0;
            masked_reg    <= 1'b0;
            key_reg       <= 32'd0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            brx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            final_reg     <= final_next;
            opc_reg       <= opc_next;
            masked_reg    <= masked_next;
            key_reg       <= key_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            brx_reg       <= brx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

[hw/rtl/websocket_frame_deframer_core.sv]
// Path: an input word is registered in the input queue, and its result word in the parser's output register.
// Throughput: one input word per cycle while the master side takes results, set by the parser step behind the queue.
// A four-word input queue lets the input side run on while the output side stalls.
// Reset is asynchronous and active low: the session is closed, the parser waits for a
// header, the queue and output register are empty, and max_payload returns to 10256.
module websocket_frame_deframer_core
    import wsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // byte_value
    input  logic              s_axis_tuser,   // command
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // data_byte, frame_opcode, status, zero pad
    output logic              m_axis_tuser,   // has_data
    output logic              m_axis_tlast,   // frame_last
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [CFG_W-1:0] max_payload_reg, max_payload_next;
    logic             item_valid;
    wsd_item_t        item;
    logic             item_pop;
    wsd_result_t      res;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_PAYLOAD) ? 32'(max_payload_reg) : 32'd0;

    always_comb
    begin
        max_payload_next = max_payload_reg;
        if (psel && penable && pwrite && pready && (paddr == REG_MAX_PAYLOAD))
        begin
            max_payload_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else
        begin
            max_payload_reg <= max_payload_next;
        end
    end

    wsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_payload (max_payload_reg),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop),
        .res_valid   (m_axis_tvalid),
        .res         (res),
        .res_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, res.status, res.frame_opcode, res.data_byte};
    assign m_axis_tuser = res.has_data;
    assign m_axis_tlast = res.frame_last;

endmodule

[hw/rtl/wsd_checker.sv]
module wsd_checker
    import wsd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result word keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    a_event_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
        else $error("word without payload is not a frame end");

    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[14:12] != ST_OK) |-> m_axis_tlast)
        else $error("error status before frame end");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14:12] <= ST_OVERSIZE) && !m_axis_tdata[15])
        else $error("status code out of range");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[bench/websocket_frame_deframer_core_tb.sv]
`timescale 1ns / 100ps

module websocket_frame_deframer_core_tb;

    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_EXT16,
        PH_EXT64,
        PH_KEY,
        PH_DATA
    } parse_phase_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'h00;   // byte_value
    logic              s_axis_tuser = 1'b0;    // command
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;           // data_byte, frame_opcode, status, zero pad
    logic              m_axis_tuser;           // has_data
    logic              m_axis_tlast;           // frame_last
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    websocket_frame_deframer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    wsd_item_t   rx_bytes_q[$];
    wsd_result_t deframed_q[$];
    int          bytes_queued = 0;
    int          bytes_taken = 0;
    int          mismatches = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          frame_budget = 0;

    wsd_item_t   word;
    wsd_result_t next_result;
    wsd_result_t seen;
    wsd_result_t want;

    // Parser state as the block should hold it.
    logic             sess_open = 1'b0;
    parse_phase_t     ph = PH_HEADER;
    int unsigned      hdr_cnt = 0;
    logic [7:0]       hdr0 = '0;
    logic             fin_q = 1'b0;
    logic [3:0]       opc_q = '0;
    logic             mask_q = 1'b0;
    logic [31:0]      key_q = '0;
    logic [63:0]      len_q = '0;
    logic [COUNT_BITS-1:0] rcvd_q = '0;
    logic [CFG_W-1:0] max_payload_q = MAX_PAYLOAD_RST;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [2:0] close_code();
        if (!fin_q)
            return ST_FRAGMENT;
        case (opc_q)
            OP_CLOSE:                             return ST_CLOSE;
            OP_TEXT, OP_BINARY, OP_PING, OP_PONG: return ST_OK;
            default:                              return ST_BAD_OP;
        endcase
    endfunction

    function automatic logic finish_frame(input logic [2:0] st, output wsd_result_t r);
        if (st != ST_OK)
            sess_open = 1'b0;
        ph = PH_HEADER;
        hdr_cnt = 0;
        r = '{1'b0, 8'h00, opc_q, 1'b1, st};
        return 1'b1;
    endfunction

    function automatic logic length_known(output wsd_result_t r);
        hdr_cnt = 0;
        rcvd_q = '0;
        r = '0;
        if (len_q > 64'(max_payload_q))
        begin
            sess_open = 1'b0;
            ph = PH_HEADER;
            r = '{1'b0, 8'h00, opc_q, 1'b1, ST_OVERSIZE};
            return 1'b1;
        end
        if (mask_q)
        begin
            ph = PH_KEY;
            return 1'b0;
        end
        if (len_q != 0)
        begin
            ph = PH_DATA;
            return 1'b0;
        end
        return finish_frame(close_code(), r);
    endfunction

    function automatic logic parse_byte(input logic is_open, input logic [7:0] b,
                                        output wsd_result_t r);
        logic [7:0] d;
        logic [2:0] st;
        r = '0;
        if (is_open)
        begin
            sess_open = 1'b1;
            ph = PH_HEADER;
            hdr_cnt = 0;
            rcvd_q = '0;
            return 1'b0;
        end
        if (!sess_open)
            return 1'b0;
        case (ph)
            PH_EXT16:
            begin
                len_q = {48'h0, len_q[7:0], b};
                hdr_cnt++;
                if (hdr_cnt >= 2)
                    return length_known(r);
                return 1'b0;
            end
            PH_EXT64:
            begin
                len_q = {len_q[55:0], b};
                hdr_cnt++;
                if (hdr_cnt >= 8)
                    return length_known(r);
                return 1'b0;
            end
            PH_KEY:
            begin
                key_q = {key_q[23:0], b};
                hdr_cnt++;
                if (hdr_cnt < 4)
                    return 1'b0;
                hdr_cnt = 0;
                if (len_q != 0)
                begin
                    ph = PH_DATA;
                    return 1'b0;
                end
                return finish_frame(close_code(), r);
            end
            PH_DATA:
            begin
                d = b;
                if (mask_q)
                    d = d ^ key_q[31 - 8 * rcvd_q[1:0] -: 8];
                rcvd_q = rcvd_q + 1'b1;
                if (64'(rcvd_q) >= len_q)
                begin
                    st = close_code();
                    void'(finish_frame(st, r));
                    r = '{1'b1, d, opc_q, 1'b1, st};
                end
                else
                begin
                    r = '{1'b1, d, opc_q, 1'b0, ST_OK};
                end
                return 1'b1;
            end
            default:
            begin
                if (hdr_cnt == 0)
                begin
                    hdr0 = b;
                    hdr_cnt = 1;
                    return 1'b0;
                end
                fin_q = hdr0[7];
                opc_q = hdr0[3:0];
                mask_q = b[7];
                len_q = {57'h0, b[6:0]};
                rcvd_q = '0;
                hdr_cnt = 0;
                key_q = '0;
                if (b[6:0] == LEN_EXT16)
                begin
                    len_q = '0;
                    ph = PH_EXT16;
                    return 1'b0;
                end
                if (b[6:0] == LEN_EXT64)
                begin
                    len_q = '0;
                    ph = PH_EXT64;
                    return 1'b0;
                end
                return length_known(r);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("ERROR at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                bytes_taken++;
                if (parse_byte(s_axis_tuser, s_axis_tdata, next_result))
                    deframed_q.push_back(next_result);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (rx_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    word = rx_bytes_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= word.data;
                    s_axis_tuser <= word.is_open;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8],
                         m_axis_tlast, m_axis_tdata[14:12]};
                if (deframed_q.size() == 0)
                begin
                    report_mismatch("unexpected word", int'(seen), 0);
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (seen.has_data !== want.has_data)
                        report_mismatch("has_data", seen.has_data, want.has_data);
                    if (seen.data_byte !== want.data_byte)
                        report_mismatch("data_byte", seen.data_byte, want.data_byte);
                    if (seen.frame_opcode !== want.frame_opcode)
                        report_mismatch("frame_opcode", seen.frame_opcode, want.frame_opcode);
                    if (seen.frame_last !== want.frame_last)
                        report_mismatch("frame_last", seen.frame_last, want.frame_last);
                    if (seen.status !== want.status)
                        report_mismatch("status", seen.status, want.status);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic add_byte(input logic [7:0] b);
        if (frame_budget > 0)
        begin
            frame_budget--;
            rx_bytes_q.push_back('{1'b0, b});
            bytes_queued++;
        end
    endtask

    task automatic push_open();
        rx_bytes_q.push_back('{1'b1, 8'($urandom)});
        bytes_queued++;
    endtask

    task automatic push_frame(input logic fin, input logic [3:0] opc, input logic msk,
                              input logic [63:0] len, input int form, input int cut,
                              output logic closes);
        logic over;
        frame_budget = cut;
        over = len > 64'(max_payload_q);
        add_byte({fin, 3'($urandom_range(7)), opc});
        case (form)
            0:
            begin
                add_byte({msk, len[6:0]});
            end
            1:
            begin
                add_byte({msk, LEN_EXT16});
                add_byte(len[15:8]);
                add_byte(len[7:0]);
            end
            default:
            begin
                add_byte({msk, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    add_byte(len[8 * i +: 8]);
            end
        endcase
        if (!over)
        begin
            if (msk)
                repeat (4) add_byte(8'($urandom));
            for (int k = 0; k < int'(len); k++)
                add_byte(8'($urandom));
        end
        closes = over || !fin ||
                 !(opc == OP_TEXT || opc == OP_BINARY || opc == OP_PING || opc == OP_PONG);
    endtask

    task automatic rand_frame(output logic closes);
        logic [3:0]  opc;
        logic        fin;
        logic        msk;
        logic [63:0] len;
        int          form;
        int          sel;
        sel = $urandom_range(99);
        if ($urandom_range(99) < 70)
        begin
            case ($urandom_range(3))
                0:       opc = OP_TEXT;
                1:       opc = OP_BINARY;
                2:       opc = OP_PING;
                default: opc = OP_PONG;
            endcase
        end
        else
        begin
            opc = 4'($urandom);
        end
        fin = $urandom_range(99) < 88;
        msk = 1'($urandom);
        if (sel < 55)
            len = $urandom_range(12);
        else if (sel < 68)
            len = $urandom_range(125, 13);
        else if (sel < 80)
            len = $urandom_range(400);
        else if (sel < 86)
            len = $urandom_range(300);
        else if (sel < 94)
            len = 64'(max_payload_q) + 1 + $urandom_range(50);
        else if (sel < 97)
            len = {32'($urandom) | 32'h1, 32'($urandom)};
        else
            len = (max_payload_q <= 400) ? 64'(max_payload_q) : 64'($urandom_range(40));
        if (sel >= 68 && sel < 80)
            form = 1;
        else if (sel >= 80 && sel < 86)
            form = 2;
        else
            form = (len < 126) ? 0 : ((len < 65536) ? 1 : 2);
        push_frame(fin, opc, msk, len, form, 1 << 30, closes);
    endtask

    task automatic run_random(input int count);
        int   start;
        int   sel;
        logic closes;
        logic need_open;
        start = bytes_queued;
        need_open = 1'b1;
        while (bytes_queued - start < count)
        begin
            sel = $urandom_range(99);
            if (need_open || sel < 6)
            begin
                push_open();
                need_open = 1'b0;
            end
            if (sel >= 6 && sel < 10)
            begin
                frame_budget = 8;
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
                need_open = 1'b1;
            end
            else if (sel >= 10 && sel < 14)
            begin
                push_frame(1'b1, OP_TEXT, 1'($urandom), 64'd30, 0, $urandom_range(1, 12),
                           closes);
                need_open = 1'b1;
            end
            else
            begin
                rand_frame(closes);
                need_open = closes;
            end
        end
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || deframed_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_max_payload(input logic [CFG_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_MAX_PAYLOAD;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        max_payload_q = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== 32'(value))
            report_mismatch("max_payload readback", prdata, 32'(value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic closes;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Bytes while closed are dropped, then one frame of each kind of ending.
        frame_budget = 2;
        add_byte(8'h00);
        add_byte(8'hFF);
        push_open();
        push_frame(1'b1, OP_TEXT, 1'b1, 64'd2, 0, 1 << 30, closes);
        push_frame(1'b1, OP_CLOSE, 1'b0, 64'd0, 0, 1 << 30, closes);
        push_open();
        push_frame(1'b0, OP_PING, 1'b0, 64'd0, 1, 1 << 30, closes);
        push_open();
        push_frame(1'b1, OP_BINARY, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 2, 1 << 30, closes);
        push_open();
        push_frame(1'b1, 4'h0, 1'b1, 64'd0, 0, 1 << 30, closes);
        wait_drained();

        set_max_payload(20'd0);
        run_random(250);
        wait_drained();

        set_max_payload(20'hFFFFF);
        src_idle_pct = 62;
        run_random(450);
        wait_drained();

        set_max_payload(20'd20);
        src_idle_pct = 0;
        sink_stall_pct = 62;
        run_random(450);
        wait_drained();

        set_max_payload(20'($urandom_range(400)));
        src_idle_pct = 13;
        sink_stall_pct = 13;
        run_random(450);
        wait_drained();

        set_max_payload(MAX_PAYLOAD_RST);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_random(400);
        wait_drained();

        if (mismatches == 0)
        begin
            $display("websocket_frame_deframer_core test passed");
        end
        else
        begin
            $display("websocket_frame_deframer_core test failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("websocket_frame_deframer_core test failed");
        $finish;
    end

endmodule
